>>> rtl/vqe_pkg.sv
// vqe_pkg: constants, payload structs and shared types of the VQ encoder.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
package vqe_pkg;

	localparam int CODEWORDS  = 64;
	localparam int BLOCK_SIDE = 4;
	localparam int ELEMS      = BLOCK_SIDE * BLOCK_SIDE;
	localparam int SAMPLE_W   = 8;
	localparam int ROW_W      = ELEMS * SAMPLE_W;
	localparam int IDX_W      = $clog2(CODEWORDS);
	localparam int ELEM_W     = $clog2(ELEMS);
	localparam int CNT_W      = $clog2(CODEWORDS + 1);
	localparam int CFG_W      = 7;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int MAX_SQ     = ((1 << SAMPLE_W) - 1) * ((1 << SAMPLE_W) - 1);
	localparam int ROWSUM_W   = $clog2(BLOCK_SIDE * MAX_SQ + 1);
	localparam int DIST_W     = $clog2(ELEMS * MAX_SQ + 1);
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [5:0] code_index;
		logic [3:0] element_index;
		logic [7:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  best_index;
		logic [19:0] best_distance;
	} out_item_t;

	// one queued request after classification
	typedef struct packed {
		logic                is_pixel;
		logic                last;
		logic [IDX_W-1:0]    code;
		logic [ELEM_W-1:0]   elem;
		logic [SAMPLE_W-1:0] sample;
	} cmd_t;

	// tag travelling with a codeword through the distance pipeline
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		logic searching;
		logic popping;
		logic res_load;
	} bk_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_WAIT
	} bk_state_t;

endpackage

>>> rtl/vq_nearest_codeword_encoder.sv
// vq_nearest_codeword_encoder: top level of the full-search VQ encoder.
// Depends on vqe_pkg, vqe_front and vqe_back.
`timescale 1ns / 1ps
// Full-search vector quantizer for 4x4 blocks of 8-bit pixels. Load requests
// write one codeword element, pixel requests fill the block buffer; the pixel
// at the last raster position starts a search over active_codewords entries
// and yields one result (lowest index wins on equal distance). Out-of-range
// requests are accepted and dropped. A four-entry queue sits behind in_ready,
// so requests keep flowing while a search runs or a result waits. A pixel
// that completes a block starts a search that reads one codebook row per
// cycle from the single memory port into a read register and the distance
// pipeline. No clearing pass follows reset. Write the register only while
// the block is idle.
module vq_nearest_codeword_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  vqe_pkg::in_item_t          in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output vqe_pkg::out_item_t         out_item,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [vqe_pkg::CFG_W-1:0]  cfg_data
);

	logic              q_valid;
	logic              q_pop;
	vqe_pkg::cmd_t     q_cmd;
	vqe_pkg::bk_stat_t stat;

	vqe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	vqe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	// a result never lands on one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_load |-> !out_valid)
		else $error("result loaded over pending result");

	// the queue stays put while a search reads the buffer
	a_no_pop_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		stat.searching |-> !stat.popping)
		else $error("queue popped during search");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_load |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule

>>> rtl/vqe_front.sv
// vqe_front: accepts requests, drops out-of-range ones, flags block ends
// and queues the rest for the back end. Depends on vqe_pkg.
`timescale 1ns / 1ps
module vqe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vqe_pkg::in_item_t in_item,
	output logic              q_valid,
	output vqe_pkg::cmd_t     q_cmd,
	input  logic              q_pop
);

	vqe_pkg::cmd_t                fifo_q [vqe_pkg::Q_DEPTH];
	logic [vqe_pkg::Q_PTR_W-1:0]  wr_q;
	logic [vqe_pkg::Q_PTR_W-1:0]  rd_q;
	logic [vqe_pkg::Q_CNT_W-1:0]  cnt_q;
	logic                         code_ok;
	logic                         elem_ok;
	logic                         keep;
	logic                         push;
	vqe_pkg::cmd_t                cmd;

	always_comb begin
		code_ok = 32'(in_item.code_index) < vqe_pkg::CODEWORDS;
		elem_ok = 32'(in_item.element_index) < vqe_pkg::ELEMS;
		keep = (in_item.req_type == vqe_pkg::REQ_PIXEL) ? elem_ok : (code_ok && elem_ok);
		cmd.is_pixel = (in_item.req_type == vqe_pkg::REQ_PIXEL);
		cmd.last = cmd.is_pixel && (32'(in_item.element_index) == vqe_pkg::ELEMS - 1);
		cmd.code = vqe_pkg::IDX_W'(in_item.code_index);
		cmd.elem = vqe_pkg::ELEM_W'(in_item.element_index);
		cmd.sample = in_item.sample_value;
	end

	assign in_ready = (cnt_q != vqe_pkg::Q_CNT_W'(vqe_pkg::Q_DEPTH));
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + vqe_pkg::Q_PTR_W'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + vqe_pkg::Q_PTR_W'(1);
			end
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + vqe_pkg::Q_CNT_W'(1);
				2'b01: cnt_q <= cnt_q - vqe_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/vqe_dist.sv
// vqe_dist: three-stage squared-distance pipeline, one codeword per cycle:
// squares, per-row sums, block sum. Depends on vqe_pkg.
`timescale 1ns / 1ps
module vqe_dist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vqe_pkg::tag_t                tag,
	input  logic [vqe_pkg::ROW_W-1:0]    code_row,
	input  logic [vqe_pkg::ROW_W-1:0]    pix_row,
	output vqe_pkg::tag_t                tag_out,
	output logic [vqe_pkg::DIST_W-1:0]   sum_out
);

	logic [vqe_pkg::SQ_W-1:0]     sq_s1 [vqe_pkg::ELEMS];
	logic [vqe_pkg::ROWSUM_W-1:0] rs_s2 [vqe_pkg::BLOCK_SIDE];
	logic [vqe_pkg::DIST_W-1:0]   sum_s3;
	vqe_pkg::tag_t                tag_s1;
	vqe_pkg::tag_t                tag_s2;
	vqe_pkg::tag_t                tag_s3;
	logic [vqe_pkg::SQ_W-1:0]     sq [vqe_pkg::ELEMS];
	logic [vqe_pkg::ROWSUM_W-1:0] rs [vqe_pkg::BLOCK_SIDE];
	logic [vqe_pkg::DIST_W-1:0]   tot;

	always_comb begin
		logic [vqe_pkg::SAMPLE_W-1:0] a;
		logic [vqe_pkg::SAMPLE_W-1:0] b;
		logic [vqe_pkg::SAMPLE_W-1:0] ad;
		for (int e = 0; e < vqe_pkg::ELEMS; e++) begin
			a = pix_row[e*vqe_pkg::SAMPLE_W +: vqe_pkg::SAMPLE_W];
			b = code_row[e*vqe_pkg::SAMPLE_W +: vqe_pkg::SAMPLE_W];
			ad = (a >= b) ? (a - b) : (b - a);
			sq[e] = vqe_pkg::SQ_W'(ad) * vqe_pkg::SQ_W'(ad);
		end
	end

	always_comb begin
		for (int r = 0; r < vqe_pkg::BLOCK_SIDE; r++) begin
			rs[r] = '0;
			for (int c = 0; c < vqe_pkg::BLOCK_SIDE; c++) begin
				rs[r] = rs[r] + vqe_pkg::ROWSUM_W'(sq_s1[r*vqe_pkg::BLOCK_SIDE + c]);
			end
		end
		tot = '0;
		for (int r = 0; r < vqe_pkg::BLOCK_SIDE; r++) begin
			tot = tot + vqe_pkg::DIST_W'(rs_s2[r]);
		end
	end

	always_ff @(posedge clk) begin
		sq_s1  <= sq;
		rs_s2  <= rs;
		sum_s3 <= tot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign tag_out = tag_s3;
	assign sum_out = sum_s3;

endmodule

>>> rtl/vqe_back.sv
// vqe_back: codebook memory, block buffer, search sequencer, running minimum
// and result register. Depends on vqe_pkg and vqe_dist.
`timescale 1ns / 1ps
module vqe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  vqe_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [vqe_pkg::CFG_W-1:0]   cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vqe_pkg::out_item_t          out_item,
	output vqe_pkg::bk_stat_t           stat
);

	logic [vqe_pkg::ROW_W-1:0]    cb_mem_q [vqe_pkg::CODEWORDS];
	logic [vqe_pkg::SAMPLE_W-1:0] buf_q [vqe_pkg::ELEMS];
	logic [vqe_pkg::ROW_W-1:0]    row_s1;
	vqe_pkg::tag_t                tag_s1;
	vqe_pkg::tag_t                tag_d;
	logic [vqe_pkg::DIST_W-1:0]   dist_d;
	logic [vqe_pkg::ROW_W-1:0]    pix_row;
	logic [vqe_pkg::CNT_W-1:0]    count_q;
	logic [vqe_pkg::IDX_W-1:0]    cnt_q;
	logic [vqe_pkg::DIST_W-1:0]   best_d_q;
	logic [vqe_pkg::IDX_W-1:0]    best_i_q;
	logic                         out_valid_q;
	vqe_pkg::out_item_t           out_q;
	vqe_pkg::bk_state_t           state_q;
	vqe_pkg::bk_state_t           state_d;
	logic                         mem_we;
	logic                         buf_we;
	logic                         issue;
	logic                         issue_last;
	logic                         take;
	logic                         res_load;
	logic [vqe_pkg::DIST_W-1:0]   fin_d;
	logic [vqe_pkg::IDX_W-1:0]    fin_i;
	logic [31:0]                  cfg_clamped;

	assign issue_last = (vqe_pkg::CNT_W'(cnt_q) == count_q - vqe_pkg::CNT_W'(1));
	assign take       = (tag_d.idx == '0) || (dist_d < best_d_q);
	assign fin_d      = take ? dist_d : best_d_q;
	assign fin_i      = take ? tag_d.idx : best_i_q;
	assign res_load   = tag_d.valid && tag_d.last;

	always_comb begin
		cfg_clamped = 32'(cfg_data);
		if (cfg_clamped == 32'd0) begin
			cfg_clamped = 32'd1;
		end
		if (cfg_clamped > vqe_pkg::CODEWORDS) begin
			cfg_clamped = vqe_pkg::CODEWORDS;
		end
	end

	always_comb begin
		for (int e = 0; e < vqe_pkg::ELEMS; e++) begin
			pix_row[e*vqe_pkg::SAMPLE_W +: vqe_pkg::SAMPLE_W] = buf_q[e];
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		mem_we  = 1'b0;
		buf_we  = 1'b0;
		issue   = 1'b0;
		case (state_q)
			vqe_pkg::BK_IDLE: begin
				if (q_valid && !(q_cmd.last && out_valid_q)) begin
					q_pop = 1'b1;
					if (q_cmd.is_pixel) begin
						buf_we = 1'b1;
						if (q_cmd.last) begin
							state_d = vqe_pkg::BK_SEARCH;
						end
					end else begin
						mem_we = 1'b1;
					end
				end
			end
			vqe_pkg::BK_SEARCH: begin
				issue = 1'b1;
				if (issue_last) begin
					state_d = vqe_pkg::BK_WAIT;
				end
			end
			vqe_pkg::BK_WAIT: begin
				if (res_load) begin
					state_d = vqe_pkg::BK_IDLE;
				end
			end
			default: state_d = vqe_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cb_mem_q[q_cmd.code][q_cmd.elem*vqe_pkg::SAMPLE_W +: vqe_pkg::SAMPLE_W] <= q_cmd.sample;
		end
		if (issue) begin
			row_s1 <= cb_mem_q[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_q[q_cmd.elem] <= q_cmd.sample;
		end
		if (tag_d.valid) begin
			best_d_q <= fin_d;
			best_i_q <= fin_i;
		end
		if (res_load) begin
			out_q.best_index    <= 6'(fin_i);
			out_q.best_distance <= 20'(fin_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vqe_pkg::BK_IDLE;
			cnt_q       <= '0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
			count_q     <= vqe_pkg::CNT_W'(vqe_pkg::CODEWORDS);
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				count_q <= vqe_pkg::CNT_W'(cfg_clamped);
			end
			if (q_pop && q_cmd.last) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + vqe_pkg::IDX_W'(1);
			end
			tag_s1.valid <= issue;
			tag_s1.last  <= issue && issue_last;
			tag_s1.idx   <= cnt_q;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	vqe_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (tag_s1),
		.code_row (row_s1),
		.pix_row  (pix_row),
		.tag_out  (tag_d),
		.sum_out  (dist_d)
	);

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign out_item       = out_q;
	assign stat.searching = (state_q == vqe_pkg::BK_SEARCH);
	assign stat.popping   = q_pop;
	assign stat.res_load  = res_load;

endmodule
